@@ sv/mll_pkg.sv @@
// Shared types and constants for the four-pole ladder lowpass.
// Used by mll_front, mll_fifo, mll_back and moog_ladder_lowpass.
package mll_pkg;

    localparam int CUT_W     = 14;
    localparam int RES_W     = 16;
    localparam int COEF_W    = 18;
    localparam int COEF_FRAC = 16;
    localparam int RES_FRAC  = 12;
    localparam int KNEE_SHIFT = 11;

    localparam int QUO_W     = 18;
    localparam int NUM_W     = 30;
    localparam int MAG_W     = 30;
    localparam int PRD_W     = NUM_W + MAG_W;
    localparam int RCP_SHIFT = 42;
    localparam int N_LANES   = 3;
    localparam int LANE_PT   = 0;
    localparam int LANE_PT1  = 1;
    localparam int LANE_RES  = 2;

    localparam logic [CUT_W-1:0] CUTOFF_MAX = 14'd8140;
    localparam logic [CUT_W-1:0] RES_KNEE   = 14'd3800;
    localparam logic [RES_W-1:0] RES_MAX    = 16'd16384;

    // ceil(2^42 / divisor) for 7100, 9230 and 4300; exact for numerators below 2^30
    localparam logic [MAG_W-1:0] RCP_PT  = 30'd619443171;
    localparam logic [MAG_W-1:0] RCP_PT1 = 30'd476494747;
    localparam logic [MAG_W-1:0] RCP_RES = 30'd1022801515;
    localparam logic [NUM_W-1:0] RND_PT  = 30'd3550;
    localparam logic [NUM_W-1:0] RND_PT1 = 30'd4615;
    localparam logic [NUM_W-1:0] RND_RES = 30'd2150;

    localparam logic signed [COEF_W-1:0] PT_OFFSET = 18'sd65536;
    localparam logic signed [COEF_W-1:0] TAP_03    = 18'sd19661;

    localparam int STG_W = 2;
    localparam logic [STG_W-1:0] STG_FIRST = 2'd0;
    localparam logic [STG_W-1:0] STG_LAST  = 2'd3;
    localparam int N_STAGES = 4;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic signed [RES_W-1:0]  q;
        logic signed [COEF_W-1:0] pt;
        logic signed [COEF_W-1:0] pt1;
    } coef_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FB,
        OP_M1,
        OP_M3,
        OP_M2
    } op_t;

endpackage

@@ sv/mll_front.sv @@
// Front end: accepts a transaction, clamps cutoff and resonance and derives the
// per-sample coefficients by constant reciprocal multiplication, one registered step.
// Depends on mll_pkg.
module mll_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  logic [mll_pkg::CUT_W-1:0]         cutoff_hz,
    input  logic [mll_pkg::RES_W-1:0]         resonance,
    output logic                              push,
    output logic signed [SAMPLE_BITS-1:0]     push_sample,
    output mll_pkg::coef_t                    push_coef,
    input  logic                              q_full
);
    import mll_pkg::*;

    front_state_t           fst_reg, fst_next;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [RES_W-2:0]       resq_reg;
    logic [NUM_W-1:0]       num_reg  [N_LANES];
    logic [QUO_W-1:0]       quo_reg  [N_LANES];

    logic [NUM_W-1:0]       init_num [N_LANES];
    logic [PRD_W-1:0]       rcp_prod [N_LANES];

    logic [CUT_W-1:0]       f_clamp;
    logic [RES_W-2:0]       res_clamp;
    logic [NUM_W-1:0]       f_wide;
    logic [NUM_W-1:0]       knee_excess;
    logic                   accept;

    assign in_stall = (fst_reg != F_IDLE);
    assign accept   = in_valid && (fst_reg == F_IDLE);

    always_comb
    begin
        f_clamp     = (cutoff_hz > CUTOFF_MAX) ? CUTOFF_MAX : cutoff_hz;
        res_clamp   = (resonance > RES_MAX) ? RES_MAX[RES_W-2:0] : resonance[RES_W-2:0];
        f_wide      = NUM_W'(f_clamp);
        knee_excess = f_wide - NUM_W'(RES_KNEE);

        init_num[LANE_PT]  = (f_wide << COEF_FRAC) + RND_PT;
        init_num[LANE_PT1] = (f_wide << COEF_FRAC) + RND_PT1;
        init_num[LANE_RES] = (f_clamp > RES_KNEE) ? ((knee_excess << KNEE_SHIFT) + RND_RES)
                                                  : '0;

        // floor(n / d) = (n * ceil(2^42 / d)) >> 42
        rcp_prod[LANE_PT]  = num_reg[LANE_PT]  * RCP_PT;
        rcp_prod[LANE_PT1] = num_reg[LANE_PT1] * RCP_PT1;
        rcp_prod[LANE_RES] = num_reg[LANE_RES] * RCP_RES;
    end

    always_comb
    begin
        fst_next = fst_reg;
        case (fst_reg)
            F_IDLE:
            begin
                if (in_valid)
                    fst_next = F_DIV;
            end
            F_DIV:
            begin
                fst_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                    fst_next = F_IDLE;
            end
            default:
            begin
                fst_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fst_reg <= F_IDLE;
        end
        else
        begin
            fst_reg <= fst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample_in;
            resq_reg <= res_clamp;
            for (int l = 0; l < N_LANES; l++)
            begin
                num_reg[l] <= init_num[l];
            end
        end
        if (fst_reg == F_DIV)
        begin
            for (int l = 0; l < N_LANES; l++)
            begin
                quo_reg[l] <= rcp_prod[l][RCP_SHIFT +: QUO_W];
            end
        end
    end

    assign push        = (fst_reg == F_PUSH) && !q_full;
    assign push_sample = x_reg;

    always_comb
    begin
        push_coef.q   = $signed({1'b0, resq_reg})
                      - $signed({{(RES_W - RES_FRAC){1'b0}}, quo_reg[LANE_RES][RES_FRAC-1:0]});
        push_coef.pt  = $signed(quo_reg[LANE_PT]) - PT_OFFSET;
        push_coef.pt1 = $signed(quo_reg[LANE_PT1]);
    end

endmodule

@@ sv/mll_fifo.sv @@
// Two-entry queue between the coefficient front end and the filter back end.
// Depends on mll_pkg.
module mll_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    import mll_pkg::*;

    logic [W-1:0]      mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

@@ sv/mll_back.sv @@
// Back end: feedback and four one-pole stages on one shared registered multiplier,
// one product a cycle unless stalled, plus output register. Depends on mll_pkg.
module mll_back #(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  logic signed [SAMPLE_BITS-1:0]  q_sample,
    input  mll_pkg::coef_t                 q_coef,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]  sample_out
);
    import mll_pkg::*;

    localparam int PW = STATE_BITS + COEF_W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] ST_MAX  = {{(SW-STATE_BITS+1){1'b0}},
                                                {(STATE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] ST_MIN  = ~ST_MAX;
    localparam logic signed [SW-1:0] SMP_MAX = {{(SW-SAMPLE_BITS+1){1'b0}},
                                                {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = ~SMP_MAX;
    localparam logic signed [PW-1:0] HALF16  = PW'(1) << (COEF_FRAC - 1);
    localparam logic signed [PW-1:0] HALF12  = PW'(1) << (RES_FRAC - 1);

    function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
        return r[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v > SMP_MAX) ? SMP_MAX : ((v < SMP_MIN) ? SMP_MIN : v);
        return r[SAMPLE_BITS-1:0];
    endfunction

    op_t                          iss_reg, iss_next;
    op_t                          prd_reg, prd_next;
    logic [STG_W-1:0]             istg_reg, istg_next;
    logic [STG_W-1:0]             pstg_reg, pstg_next;
    logic                         out_valid_reg, out_valid_next;

    logic signed [STATE_BITS-1:0] prev_in_reg [N_STAGES];
    logic signed [STATE_BITS-1:0] st_out_reg  [N_STAGES];

    logic signed [SAMPLE_BITS-1:0] x_reg;
    coef_t                        coef_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [PW-1:0]         m3_reg;
    logic signed [STATE_BITS-1:0] u_reg;
    logic signed [STATE_BITS-1:0] t_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic                         hold;
    logic                         adv;
    logic                         start;
    logic                         out_load;
    logic signed [COEF_W-1:0]     mul_a;
    logic signed [STATE_BITS-1:0] mul_b;
    logic signed [PW-1:0]         prod_next;
    logic signed [PW-1:0]         r16;
    logic signed [PW-1:0]         r12;
    logic signed [SW-1:0]         fb_sum;
    logic signed [SW-1:0]         t_sum;
    logic signed [SW-1:0]         y_sum;
    logic signed [STATE_BITS-1:0] fb_val;
    logic signed [STATE_BITS-1:0] t_val;
    logic signed [STATE_BITS-1:0] y_val;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign q_pop      = start;

    always_comb
    begin
        hold     = (prd_reg == OP_M2) && (pstg_reg == STG_LAST) && out_valid_reg && out_stall;
        adv      = !hold;
        start    = (iss_reg == OP_NONE) && (prd_reg == OP_NONE) && !q_empty;
        out_load = adv && (prd_reg == OP_M2) && (pstg_reg == STG_LAST);

        iss_next  = iss_reg;
        istg_next = istg_reg;
        if (adv)
        begin
            case (iss_reg)
                OP_NONE:
                begin
                    if (start)
                        iss_next = OP_FB;
                end
                OP_FB:
                begin
                    iss_next  = OP_M1;
                    istg_next = STG_FIRST;
                end
                OP_M1:
                begin
                    iss_next = OP_M3;
                end
                OP_M3:
                begin
                    iss_next = OP_M2;
                end
                OP_M2:
                begin
                    if (istg_reg == STG_LAST)
                    begin
                        iss_next = OP_NONE;
                    end
                    else
                    begin
                        iss_next  = OP_M1;
                        istg_next = istg_reg + 1'b1;
                    end
                end
                default:
                begin
                    iss_next = OP_NONE;
                end
            endcase
        end
        prd_next  = adv ? iss_reg  : prd_reg;
        pstg_next = adv ? istg_reg : pstg_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // multiplier operand select
    always_comb
    begin
        case (iss_reg)
            OP_FB:
            begin
                mul_a = COEF_W'(coef_reg.q);
                mul_b = st_out_reg[STG_LAST];
            end
            OP_M1:
            begin
                mul_a = TAP_03;
                mul_b = prev_in_reg[istg_reg];
            end
            OP_M3:
            begin
                mul_a = coef_reg.pt;
                mul_b = st_out_reg[istg_reg];
            end
            OP_M2:
            begin
                mul_a = coef_reg.pt1;
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        r16    = (prod_reg + HALF16) >>> COEF_FRAC;
        r12    = (prod_reg + HALF12) >>> RES_FRAC;
        fb_sum = {{(SW-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg} - {r12[PW-1], r12};
        t_sum  = {{(SW-STATE_BITS){u_reg[STATE_BITS-1]}}, u_reg} + {r16[PW-1], r16};
        y_sum  = {r16[PW-1], r16} - {m3_reg[PW-1], m3_reg};
        fb_val = sat_st(fb_sum);
        t_val  = sat_st(t_sum);
        y_val  = sat_st(y_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg       <= OP_NONE;
            prd_reg       <= OP_NONE;
            istg_reg      <= STG_FIRST;
            pstg_reg      <= STG_FIRST;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < N_STAGES; s++)
            begin
                prev_in_reg[s] <= '0;
                st_out_reg[s]  <= '0;
            end
        end
        else
        begin
            iss_reg       <= iss_next;
            prd_reg       <= prd_next;
            istg_reg      <= istg_next;
            pstg_reg      <= pstg_next;
            out_valid_reg <= out_valid_next;
            if (adv && (prd_reg == OP_M2))
            begin
                prev_in_reg[pstg_reg] <= u_reg;
                st_out_reg[pstg_reg]  <= y_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= q_sample;
            coef_reg <= q_coef;
        end
        if (adv)
        begin
            prod_reg <= prod_next;
            case (prd_reg)
                OP_FB:
                begin
                    u_reg <= fb_val;
                end
                OP_M1:
                begin
                    t_reg <= t_val;
                end
                OP_M3:
                begin
                    m3_reg <= r16;
                end
                OP_M2:
                begin
                    u_reg <= y_val;
                end
                default:
                begin
                end
            endcase
        end
        if (out_load)
            sample_out_reg <= sat_smp({{(SW-STATE_BITS){y_val[STATE_BITS-1]}}, y_val});
    end

endmodule

@@ sv/moog_ladder_lowpass.sv @@
// Top level of the four-pole resonant ladder lowpass.
// Instantiates mll_front, mll_fifo and mll_back; depends on mll_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with sample_in (signed Q0.23), cutoff_hz
//   (Hz, capped at 8140) and resonance (unsigned Q4.12, capped at 4.0). A
//   transaction is taken at a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with sample_out (signed Q0.23,
//   saturated); one output transaction per input transaction, in order.
//   Sequencing: set by the back end's single shared multiplier (13 products per
//   sample), which starts a sample only once the previous one has left it. The
//   front end finishes its reciprocal-multiply coefficient step for one sample
//   before it accepts the next, and runs ahead of the back end through a
//   two-entry queue.
//   Stall: while out_stall holds a result, the back end waits on its last step;
//   in_stall is high while the front end works on an accepted transaction and
//   stays high while the queue is full.
//   Reset: rst_n clears all stage memories to zero and empties the pipeline.
module moog_ladder_lowpass #(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  logic [mll_pkg::CUT_W-1:0]         cutoff_hz,
    input  logic [mll_pkg::RES_W-1:0]         resonance,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     sample_out
);
    import mll_pkg::*;

    localparam int QW = SAMPLE_BITS + $bits(coef_t);

    logic                          q_push;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_empty;
    logic signed [SAMPLE_BITS-1:0] push_sample;
    coef_t                         push_coef;
    logic [QW-1:0]                 q_rdata;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    coef_t                         q_coef;

    assign q_sample = q_rdata[QW-1 -: SAMPLE_BITS];
    assign q_coef   = q_rdata[$bits(coef_t)-1:0];

    mll_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .cutoff_hz   (cutoff_hz),
        .resonance   (resonance),
        .push        (q_push),
        .push_sample (push_sample),
        .push_coef   (push_coef),
        .q_full      (q_full)
    );

    mll_fifo #(
        .W (QW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({push_sample, push_coef}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    mll_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_sample   (q_sample),
        .q_coef     (q_coef),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

`ifndef SYNTHESIS
    a_front_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("front end not busy after accepting a transaction");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front end pushed into a full queue");
`endif

endmodule
